// File: design/bdna_pkg.sv
package bdna_pkg;

   localparam int SAMPLE_W      = 8;
   localparam int WIDTH_REG_W   = 12;
   localparam int HEIGHT_REG_W  = 13;
   // row counters run up to height plus one while the last row drains
   localparam int ROW_W         = HEIGHT_REG_W + 1;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int SUM_W         = 10;
   localparam int CNT_W         = 3;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_idx_type;

   // bayer phase of a pixel: {row odd, column odd}
   typedef enum logic [1:0] {
      PH_GB_GREEN = 2'b00,
      PH_GB_BLUE  = 2'b01,
      PH_RG_RED   = 2'b10,
      PH_RG_GREEN = 2'b11
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      left_ok;
      logic      right_ok;
      logic      up_ok;
      logic      down_ok;
      logic      last;
   } pos_type;

   typedef struct packed {
      logic    advance;
      logic    shift;
      logic    zero_sample;
      pos_type pos;
   } cmd_type;

endpackage

// File: design/bdna_ifs.sv
interface bdna_req_if;
   logic                          valid;
   logic                          ready;
   logic [bdna_pkg::SAMPLE_W-1:0] sample;
   logic                          pad;

   modport source (output valid, output sample, output pad, input ready);
   modport sink   (input valid, input sample, input pad, output ready);
endinterface

interface bdna_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bdna_pkg::SAMPLE_W-1:0] red;
   logic [bdna_pkg::SAMPLE_W-1:0] green;
   logic [bdna_pkg::SAMPLE_W-1:0] blue;
   logic                          frame_end;

   modport source (output valid, output red, output green, output blue,
                   output frame_end, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_end, output ready);
endinterface

interface bdna_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bdna_pkg::CSR_IDX_W-1:0]  index;
   logic [bdna_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/bayer_demosaic_neighbor_average_core.sv
// channel   dir  handshake       payload
// req_bus   in   valid / ready   sample[7:0], pad
// rsp_bus   out  valid / ready   red[7:0], green[7:0], blue[7:0], frame_end
// csr_bus   in   valid / ready   index[1:0], data[12:0] (0 frame_width, 1 frame_height)
//
// one input word per clock while rsp_bus is ready; the line store has a
// single registered read port, prefetched for the next column, which sets that
// rate. a pixel leaves rsp_bus through the window, sum and output registers,
// and pixels trail input by frame_width + 1 words (filler words drain the end).
// synchronous active-high reset: frame counters and pipeline valids clear,
// registers return to 640 x 480; line store contents stay undefined.
// a stalled rsp_bus freezes the whole pipeline and drops req_bus ready.
module bayer_demosaic_neighbor_average_core #(
   parameter int MAX_WIDTH = bdna_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   bdna_req_if.sink          req_bus,
   bdna_rsp_if.source        rsp_bus,
   bdna_csr_if.sink          csr_bus
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   // controller to datapath commands
   bdna_pkg::cmd_type cmd;
   logic [COL_W-1:0]  rd_addr;
   logic [COL_W-1:0]  wr_addr;

   // frame counters, register file, pipeline valids and handshakes
   bdna_ctrl #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_pad   (req_bus.pad),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .csr_ready (csr_bus.ready),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr)
   );

   // line store, 3x3 window, neighbor sums, means and output word
   bdna_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .req_sample    (req_bus.sample),
      .rsp_red       (rsp_bus.red),
      .rsp_green     (rsp_bus.green),
      .rsp_blue      (rsp_bus.blue),
      .rsp_frame_end (rsp_bus.frame_end)
   );

endmodule

// File: design/bdna_dpath.sv
module bdna_dpath #(
   parameter int MAX_WIDTH = bdna_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  bdna_pkg::cmd_type             cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [bdna_pkg::SAMPLE_W-1:0] req_sample,
   output logic [bdna_pkg::SAMPLE_W-1:0] rsp_red,
   output logic [bdna_pkg::SAMPLE_W-1:0] rsp_green,
   output logic [bdna_pkg::SAMPLE_W-1:0] rsp_blue,
   output logic                          rsp_frame_end
);

   localparam int SW           = bdna_pkg::SAMPLE_W;
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;
   localparam int PROD_W       = bdna_pkg::SUM_W + RECIP3_SHIFT - 1;

   // truncated mean of up to four samples; count three via reciprocal
   function automatic logic [SW-1:0] mean_of(input logic [bdna_pkg::SUM_W-1:0] sum,
                                             input logic [bdna_pkg::CNT_W-1:0] cnt);
      logic [PROD_W-1:0] prod;
      logic [SW-1:0]     res;
      prod = PROD_W'(sum) * PROD_W'(RECIP3);
      case (cnt)
         3'd1:    res = sum[SW-1:0];
         3'd2:    res = sum[SW:1];
         3'd3:    res = prod[RECIP3_SHIFT +: SW];
         3'd4:    res = sum[SW+1:2];
         default: res = '0;
      endcase
      return res;
   endfunction

   // line store: {two rows up, one row up} per column
   logic [2*SW-1:0] line_mem [MAX_WIDTH];
   logic [2*SW-1:0] line_rd_ff;
   logic [2*SW-1:0] line_wr;
   logic [SW-1:0]   sample_in;

   logic [SW-1:0] win_ff [3][3];
   bdna_pkg::pos_type pos_ff;

   logic [bdna_pkg::SUM_W-1:0] sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;
   logic [bdna_pkg::CNT_W-1:0] cnt_a_in, cnt_b_in, cnt_a_ff, cnt_b_ff;
   logic [SW-1:0]              center_ff;
   bdna_pkg::phase_type        phase_ff;
   logic                       last_ff;

   logic [SW-1:0] red_in, green_in, blue_in;
   logic [SW-1:0] red_ff, green_ff, blue_ff;
   logic          frame_end_ff;

   assign sample_in = cmd.zero_sample ? '0 : req_sample;
   assign line_wr   = {line_rd_ff[SW-1:0], sample_in};

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         line_mem[wr_addr] <= line_wr;
      end
      // forward the word written this cycle when a one-pixel row rereads it
      if (cmd.shift && (wr_addr == rd_addr)) begin
         line_rd_ff <= line_wr;
      end else begin
         line_rd_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line_rd_ff[2*SW-1:SW];
         win_ff[1][2] <= line_rd_ff[SW-1:0];
         win_ff[2][2] <= sample_in;
      end
      if (cmd.advance) begin
         pos_ff <= cmd.pos;
      end
   end

   // neighbor groups: horizontal, vertical, diagonal
   logic [SW-1:0]   nb_l, nb_r, nb_u, nb_d, nb_ul, nb_ur, nb_dl, nb_dr;
   logic [SW:0]     sum_h, sum_v;
   logic [1:0]      cnt_h, cnt_v;
   logic [bdna_pkg::SUM_W-1:0] sum_d, sum_hv;
   logic [bdna_pkg::CNT_W-1:0] cnt_d, cnt_hv;

   always_comb begin
      nb_l  = pos_ff.left_ok  ? win_ff[1][0] : '0;
      nb_r  = pos_ff.right_ok ? win_ff[1][2] : '0;
      nb_u  = pos_ff.up_ok    ? win_ff[0][1] : '0;
      nb_d  = pos_ff.down_ok  ? win_ff[2][1] : '0;
      nb_ul = (pos_ff.up_ok   && pos_ff.left_ok)  ? win_ff[0][0] : '0;
      nb_ur = (pos_ff.up_ok   && pos_ff.right_ok) ? win_ff[0][2] : '0;
      nb_dl = (pos_ff.down_ok && pos_ff.left_ok)  ? win_ff[2][0] : '0;
      nb_dr = (pos_ff.down_ok && pos_ff.right_ok) ? win_ff[2][2] : '0;

      sum_h  = (SW+1)'(nb_l) + (SW+1)'(nb_r);
      sum_v  = (SW+1)'(nb_u) + (SW+1)'(nb_d);
      cnt_h  = 2'(pos_ff.left_ok) + 2'(pos_ff.right_ok);
      cnt_v  = 2'(pos_ff.up_ok) + 2'(pos_ff.down_ok);
      sum_d  = bdna_pkg::SUM_W'(nb_ul) + bdna_pkg::SUM_W'(nb_ur)
             + bdna_pkg::SUM_W'(nb_dl) + bdna_pkg::SUM_W'(nb_dr);
      cnt_d  = bdna_pkg::CNT_W'(pos_ff.up_ok && pos_ff.left_ok)
             + bdna_pkg::CNT_W'(pos_ff.up_ok && pos_ff.right_ok)
             + bdna_pkg::CNT_W'(pos_ff.down_ok && pos_ff.left_ok)
             + bdna_pkg::CNT_W'(pos_ff.down_ok && pos_ff.right_ok);
      sum_hv = bdna_pkg::SUM_W'(sum_h) + bdna_pkg::SUM_W'(sum_v);
      cnt_hv = bdna_pkg::CNT_W'(cnt_h) + bdna_pkg::CNT_W'(cnt_v);

      case (pos_ff.phase)
         bdna_pkg::PH_GB_GREEN: begin
            sum_a_in = bdna_pkg::SUM_W'(sum_v);
            cnt_a_in = bdna_pkg::CNT_W'(cnt_v);
            sum_b_in = bdna_pkg::SUM_W'(sum_h);
            cnt_b_in = bdna_pkg::CNT_W'(cnt_h);
         end
         bdna_pkg::PH_GB_BLUE, bdna_pkg::PH_RG_RED: begin
            sum_a_in = sum_hv;
            cnt_a_in = cnt_hv;
            sum_b_in = sum_d;
            cnt_b_in = cnt_d;
         end
         bdna_pkg::PH_RG_GREEN: begin
            sum_a_in = bdna_pkg::SUM_W'(sum_h);
            cnt_a_in = bdna_pkg::CNT_W'(cnt_h);
            sum_b_in = bdna_pkg::SUM_W'(sum_v);
            cnt_b_in = bdna_pkg::CNT_W'(cnt_v);
         end
         default: begin
            sum_a_in = '0;
            cnt_a_in = '0;
            sum_b_in = '0;
            cnt_b_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         sum_a_ff  <= sum_a_in;
         cnt_a_ff  <= cnt_a_in;
         sum_b_ff  <= sum_b_in;
         cnt_b_ff  <= cnt_b_in;
         center_ff <= win_ff[1][1];
         phase_ff  <= pos_ff.phase;
         last_ff   <= pos_ff.last;
      end
   end

   logic [SW-1:0] avg_a, avg_b;

   always_comb begin
      avg_a = mean_of(sum_a_ff, cnt_a_ff);
      avg_b = mean_of(sum_b_ff, cnt_b_ff);
      case (phase_ff)
         bdna_pkg::PH_GB_GREEN: begin
            red_in   = avg_a;
            green_in = center_ff;
            blue_in  = avg_b;
         end
         bdna_pkg::PH_GB_BLUE: begin
            red_in   = avg_b;
            green_in = avg_a;
            blue_in  = center_ff;
         end
         bdna_pkg::PH_RG_RED: begin
            red_in   = center_ff;
            green_in = avg_a;
            blue_in  = avg_b;
         end
         bdna_pkg::PH_RG_GREEN: begin
            red_in   = avg_a;
            green_in = center_ff;
            blue_in  = avg_b;
         end
         default: begin
            red_in   = '0;
            green_in = '0;
            blue_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         frame_end_ff <= last_ff;
      end
   end

   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

// File: design/bdna_ctrl.sv
module bdna_ctrl #(
   parameter int MAX_WIDTH = bdna_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_pad,
   output logic                            req_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   input  logic                            csr_valid,
   input  logic [bdna_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdna_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                            csr_ready,
   output bdna_pkg::cmd_type               cmd,
   output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
   output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WR_W  = bdna_pkg::WIDTH_REG_W;
   localparam int HR_W  = bdna_pkg::HEIGHT_REG_W;
   localparam int ROW_W = bdna_pkg::ROW_W;
   localparam int CMP_W = ((COL_W > WR_W) ? COL_W : WR_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_ACTIVE = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [WR_W-1:0]    width_ff;
   logic [HR_W-1:0]    height_ff;
   logic [COL_W-1:0]   in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic               s1_vld_ff, s2_vld_ff, out_vld_ff;

   logic [WR_W-1:0]    w_eff;
   logic [HR_W-1:0]    h_eff;
   logic               advance, accept, shift, emit, col_wrap;
   bdna_pkg::pos_type  pos;

   assign csr_ready = 1'b1;
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = out_vld_ff;
   assign accept    = req_valid && advance;
   // a filler word with no frame in progress is swallowed
   assign shift     = accept && !(req_pad && (state_ff == ST_IDLE));

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WR_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WR_W'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff == '0) ? HR_W'(1) : height_ff;

      col_wrap     = (CMP_W'(in_col_ff) + CMP_W'(1)) >= CMP_W'(w_eff);
      emit         = (in_row_ff >= ROW_W'(2))
                   || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      pos.phase    = bdna_pkg::phase_type'({out_row_ff[0], out_col_ff[0]});
      pos.left_ok  = out_col_ff != '0;
      pos.right_ok = (CMP_W'(out_col_ff) + CMP_W'(1)) < CMP_W'(w_eff);
      pos.up_ok    = out_row_ff != '0;
      pos.down_ok  = (out_row_ff + ROW_W'(1)) < ROW_W'(h_eff);
      pos.last     = !pos.down_ok && !pos.right_ok;

      state_in   = state_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (shift) begin
         state_in = ST_ACTIVE;
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit) begin
            if (pos.last) begin
               state_in   = ST_IDLE;
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!pos.right_ok) begin
               out_col_in = '0;
               out_row_in = out_row_ff + ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end

      cmd.advance     = advance;
      cmd.shift       = shift;
      cmd.zero_sample = req_pad || (in_row_ff >= ROW_W'(h_eff));
      cmd.pos         = pos;
   end

   assign rd_addr = in_col_in;
   assign wr_addr = in_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         width_ff   <= bdna_pkg::WIDTH_RESET;
         height_ff  <= bdna_pkg::HEIGHT_RESET;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         if (advance) begin
            s1_vld_ff  <= shift && emit;
            s2_vld_ff  <= s1_vld_ff;
            out_vld_ff <= s2_vld_ff;
         end
         if (csr_valid) begin
            case (csr_index)
               bdna_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[WR_W-1:0];
               bdna_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data[HR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // idle means no position counted yet in this frame
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (in_col_ff == '0 && in_row_ff == '0
                                 && out_col_ff == '0 && out_row_ff == '0))
      else $error("idle state with nonzero position counters");

   assert property (@(posedge clock) disable iff (reset)
      (shift && emit) |-> (state_ff == ST_ACTIVE))
      else $error("pixel emitted outside a frame");

   assert property (@(posedge clock) disable iff (reset)
      (shift && emit && pos.last) |=> (state_ff == ST_IDLE))
      else $error("frame did not close after its last pixel");

   assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(s2_vld_ff))
      else $error("output word appeared without a pipeline word behind it");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while output is stalled");

endmodule

// File: verif/bdna_pixel_checker.sv
module bdna_pixel_checker
   import bdna_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bdna_req_if         req_bus,
   bdna_rsp_if         rsp_bus,
   bdna_csr_if         csr_bus,
   output int unsigned fail_count,
   output int unsigned pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORT_LINES = 200;

   typedef enum int {
      RED   = 0,
      GREEN = 1,
      BLUE  = 2
   } colour_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic                frame_end;
   } pixel_type;

   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [SAMPLE_W-1:0]     last_line  [MAX_WIDTH];
   logic [SAMPLE_W-1:0]     older_line [MAX_WIDTH];
   logic [SAMPLE_W-1:0]     nbhd [3][3];
   int unsigned             in_col, in_row, out_col, out_row;
   pixel_type               expected_pixels [$];
   int unsigned             pixels_seen;

   function automatic colour_type colour_of(int unsigned row, int unsigned col);
      phase_type ph;
      ph = phase_type'({row[0], col[0]});
      case (ph)
         PH_GB_BLUE: return BLUE;
         PH_RG_RED:  return RED;
         default:    return GREEN;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORT_LINES) $display("mismatch: %s", msg);
   endtask

   // one accepted word through the demosaic; may queue one pixel
   task automatic demosaic_step(input logic [SAMPLE_W-1:0] sample, input logic pad);
      int unsigned         w, h, c;
      int unsigned         sum [3];
      int unsigned         cnt [3];
      int                  r, q;
      logic [SAMPLE_W-1:0] s;
      logic [SAMPLE_W-1:0] val [3];
      logic                emit, last;
      colour_type          nc;
      pixel_type           px;
      w = width_reg;
      if (w == 0) w = 1;
      else if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = height_reg;
      if (h == 0) h = 1;
      // filler with no frame in progress is dropped
      if (pad && in_row == 0 && in_col == 0 && out_row == 0 && out_col == 0) return;
      s = (pad || in_row >= h) ? '0 : sample;
      c = in_col % MAX_WIDTH;
      for (int k = 0; k < 3; k++) begin
         nbhd[k][0] = nbhd[k][1];
         nbhd[k][1] = nbhd[k][2];
      end
      nbhd[0][2]    = older_line[c];
      nbhd[1][2]    = last_line[c];
      nbhd[2][2]    = s;
      older_line[c] = last_line[c];
      last_line[c]  = s;
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      if (!emit) return;
      sum = '{0, 0, 0};
      cnt = '{0, 0, 0};
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = int'(out_row) + dr;
            q = int'(out_col) + dc;
            if ((dr == 0 && dc == 0) || r < 0 || q < 0 || r >= int'(h) || q >= int'(w))
               continue;
            nc = colour_of(r, q);
            sum[nc] += nbhd[1 + dr][1 + dc];
            cnt[nc]++;
         end
      end
      for (int k = 0; k < 3; k++)
         val[k] = (cnt[k] != 0) ? SAMPLE_W'(sum[k] / cnt[k]) : '0;
      val[colour_of(out_row, out_col)] = nbhd[1][1];
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      px.red       = val[RED];
      px.green     = val[GREEN];
      px.blue      = val[BLUE];
      px.frame_end = last;
      expected_pixels.push_back(px);
      if (last) begin
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("pixel %0d arrived with none expected", pixels_seen));
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_bus.red !== want.red)
         report_mismatch($sformatf("pixel %0d red: expected %0d, got %0d",
                                   pixels_seen, want.red, rsp_bus.red));
      if (rsp_bus.green !== want.green)
         report_mismatch($sformatf("pixel %0d green: expected %0d, got %0d",
                                   pixels_seen, want.green, rsp_bus.green));
      if (rsp_bus.blue !== want.blue)
         report_mismatch($sformatf("pixel %0d blue: expected %0d, got %0d",
                                   pixels_seen, want.blue, rsp_bus.blue));
      if (rsp_bus.frame_end !== want.frame_end)
         report_mismatch($sformatf("pixel %0d frame_end: expected %0b, got %0b",
                                   pixels_seen, want.frame_end, rsp_bus.frame_end));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = WIDTH_RESET;
         height_reg  = HEIGHT_RESET;
         in_col      = 0;
         in_row      = 0;
         out_col     = 0;
         out_row     = 0;
         pixels_seen = 0;
         fail_count  = 0;
         foreach (nbhd[i, j]) nbhd[i][j] = '0;
         expected_pixels.delete();
      end else begin
         // compare before predicting, a pixel never leaves on its own word's edge
         if (rsp_bus.valid && rsp_bus.ready) check_pixel();
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_idx_type'(csr_bus.index))
               CSR_FRAME_WIDTH:  width_reg  = csr_bus.data[WIDTH_REG_W-1:0];
               CSR_FRAME_HEIGHT: height_reg = csr_bus.data[HEIGHT_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) demosaic_step(req_bus.sample, req_bus.pad);
      end
      pending <= expected_pixels.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdna_pkg::*;

   localparam int RESET_CYCLES    = 9;
   // pixel leaves after its word passes the pipeline registers; allow generous slack
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   // longest silent stretch in a good run is the hold-off;
   // random gaps at 87 percent stay well under the limit
   localparam int STALL_LIMIT     = 4000;
   localparam int RANDOM_WORDS    = 720;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;
   int unsigned quiet_cycles = 0;
   int unsigned eff_w, eff_h;
   int unsigned phase_words;
   int          req_idle_pct  = 0;
   int          rsp_stall_pct = 0;
   bit          hold_off_request = 1'b0;

   bdna_req_if req_bus ();
   bdna_rsp_if rsp_bus ();
   bdna_csr_if csr_bus ();

   bayer_demosaic_neighbor_average_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bdna_pixel_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6ns clock = ~clock;

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d pixels pending",
                  quiet_cycles, pending);
         $display("** bayer_demosaic_neighbor_average_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one word, hold it until taken, then maybe leave the bus idle
   // unless idled, valid stays high on return so back-to-back words run without a gap
   task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic is_pad);
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      req_bus.pad    <= is_pad;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid  <= 1'b0;
         req_bus.sample <= SAMPLE_W'($urandom);
         @(posedge clock);
      end
   endtask

   // both registers in one burst; valid held across the two words
   task automatic set_frame_size(input logic [CSR_DATA_W-1:0] width_word,
                                 input logic [CSR_DATA_W-1:0] height_word);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_FRAME_WIDTH;
      csr_bus.data  <= width_word;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.index <= CSR_FRAME_HEIGHT;
      csr_bus.data  <= height_word;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      // width register is 12 bits, clamped to 1..max width; height 0 acts as 1
      eff_w = width_word[WIDTH_REG_W-1:0];
      if (eff_w == 0) eff_w = 1;
      else if (eff_w > MAX_WIDTH_DEF) eff_w = MAX_WIDTH_DEF;
      eff_h = height_word;
      if (eff_h == 0) eff_h = 1;
   endtask

   // stop offering, wait for every pixel and for the pipe to go quiet
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do begin
         while (pending != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (pending != 0);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // one whole frame at the current size, then width+1 filler words to drain
   task automatic run_frame();
      // filler between frames is ignored by the block
      repeat ($urandom_range(2)) send_word(pick_sample(), 1'b1);
      for (int unsigned i = 0; i < eff_w * eff_h; i++)
         send_word(pick_sample(), (i != 0) && ($urandom_range(15) == 0));
      // during drain the pad bit does not matter, mix both
      repeat (eff_w + 1) send_word(pick_sample(), 1'($urandom_range(1)));
      phase_words += eff_w * eff_h + eff_w + 1;
   endtask

   initial begin
      int unsigned w, h;
      logic        first_frame;

      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      req_bus.pad    <= 1'b0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= CSR_FRAME_WIDTH;
      csr_bus.data   <= '0;
      eff_w          = 640;
      eff_h          = 480;
      phase_words    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed frames ---
      // zero width and height registers: a 1x1 frame, no neighbors at all
      set_frame_size('0, '0);
      send_word(8'hAA, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'h00, 1'b1);
      drain_results();

      // 2x2 with a filler word inside the frame, samples on drain words
      set_frame_size(13'd2, 13'd2);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h55, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      drain_results();

      // one row, width written with its unused top bit set
      set_frame_size(13'h1003, 13'd1);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      repeat (4) send_word(8'h0F, 1'b0);
      drain_results();

      // one column
      set_frame_size(13'd1, 13'd3);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hF0, 1'b1);
      send_word(8'h3C, 1'b0);
      drain_results();

      // --- random frames, four idling mixes ---
      for (int ph = 0; ph < 4; ph++) begin
         drain_results();
         case (ph)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 87; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 87; end
            default: begin req_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         phase_words = 0;
         if (ph == 0) begin
            // sender keeps offering while the receiver holds off
            set_frame_size(13'd32, 13'd8);
            hold_off_request = 1'b1;
            run_frame();
         end
         first_frame = 1'b1;
         while (phase_words < RANDOM_WORDS / 4) begin
            // mostly tiny frames so that frame edges dominate
            if (first_frame || $urandom_range(1) == 1) begin
               drain_results();
               w = ($urandom_range(7) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
               h = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
               if (w == 1 && $urandom_range(1) == 1) w = 0;
               if (h == 1 && $urandom_range(1) == 1) h = 0;
               set_frame_size({1'($urandom_range(1)), WIDTH_REG_W'(w)}, CSR_DATA_W'(h));
               first_frame = 1'b0;
            end
            run_frame();
         end
      end

      drain_results();
      if (fail_count == 0 && pending == 0) begin
         $display("** bayer_demosaic_neighbor_average_core: PASSED **");
      end else begin
         $display("** bayer_demosaic_neighbor_average_core: FAILED **");
      end
      $finish;
   end

endmodule
